FILE: hw/rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder with Latin-1 fallback.
package u8d_pkg;

    localparam int CP_W    = 21;
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int HC_N    = 2;

    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [1:0] LEAD_TAG = 2'b11;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    localparam logic [7:0] MASK_LEAD4 = 8'h07;
    localparam logic [7:0] MASK_LEAD3 = 8'h0f;
    localparam logic [7:0] MASK_LEAD2 = 8'h1f;
    localparam logic [7:0] MASK_CONT  = 8'h3f;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            fell_back;
        logic            run_last;
    } t_out;

    typedef t_out [MAX_RES-1:0] t_out_list;

    typedef struct packed {
        logic [7:0]      lead;
        logic [1:0]      needed;
        logic [1:0]      seen;
        logic [CP_W-1:0] pv;
    } t_dec_state;

    typedef struct packed {
        logic       we;
        logic       addr;
        logic [7:0] data;
    } t_hc_wr;

    function automatic t_out raw_word(input logic [7:0] b, input logic fb);
        t_out w;
        w.code_point = {{(CP_W-8){1'b0}}, b};
        w.fell_back  = fb;
        w.run_last   = 1'b0;
        return w;
    endfunction

endpackage

FILE: hw/rtl/u8d_decode.sv
// Single-pass decode of one byte against the pending sequence into up to four words.
module u8d_decode (
    input  u8d_pkg::t_in                  i_in,
    input  u8d_pkg::t_dec_state           i_st,
    input  logic [u8d_pkg::HC_N-1:0][7:0] i_hc,
    output u8d_pkg::t_dec_state           o_st,
    output u8d_pkg::t_hc_wr               o_hc_wr,
    output u8d_pkg::t_out_list            o_list,
    output logic [u8d_pkg::CNT_W-1:0]     o_cnt
);
    import u8d_pkg::*;

    logic [7:0]       b;
    logic             is_cont;
    logic [1:0]       seen1;
    logic [CP_W-1:0]  pv1;
    logic [HC_N-1:0][7:0] hc_now;
    logic [1:0]       fl_n;
    logic             do_flush;
    logic             do_fresh;
    logic [CNT_W-1:0] cnt;
    t_out_list        res;

    assign b       = i_in.byte_in;
    assign is_cont = (b[7:6] == CONT_TAG);

    always_comb begin
        o_st     = i_st;
        o_hc_wr  = '0;
        res      = '0;
        cnt      = '0;
        hc_now   = i_hc;
        seen1    = i_st.seen + 2'd1;
        pv1      = {i_st.pv[CP_W-7:0], b[5:0]};
        fl_n     = i_st.seen;
        do_flush = 1'b0;
        do_fresh = 1'b0;

        if (i_st.needed != NEED_NONE) begin
            if (is_cont) begin
                if (i_st.seen < 2'd2) begin
                    o_hc_wr.we   = 1'b1;
                    o_hc_wr.addr = i_st.seen[0];
                    o_hc_wr.data = b;
                    hc_now[i_st.seen[0]] = b;
                end
                if (seen1 >= i_st.needed) begin
                    res[cnt[IDX_W-1:0]] = '{code_point: pv1, fell_back: 1'b0,
                                            run_last: 1'b0};
                    cnt         = cnt + 1'b1;
                    o_st.needed = NEED_NONE;
                    o_st.seen   = 2'd0;
                    o_st.pv     = '0;
                end else begin
                    o_st.seen = seen1;
                    o_st.pv   = pv1;
                    fl_n      = seen1;
                    do_flush  = i_in.text_end;
                end
            end else begin
                do_flush = 1'b1;
                do_fresh = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        if (do_flush) begin
            res[cnt[IDX_W-1:0]] = raw_word(i_st.lead, 1'b1);
            cnt = cnt + 1'b1;
            if (fl_n >= 2'd1) begin
                res[cnt[IDX_W-1:0]] = raw_word(hc_now[0], 1'b1);
                cnt = cnt + 1'b1;
            end
            if (fl_n >= 2'd2) begin
                res[cnt[IDX_W-1:0]] = raw_word(hc_now[1], 1'b1);
                cnt = cnt + 1'b1;
            end
            o_st.needed = NEED_NONE;
            o_st.seen   = 2'd0;
            o_st.pv     = '0;
        end

        if (do_fresh) begin
            if (b[7] == 1'b0) begin
                res[cnt[IDX_W-1:0]] = raw_word(b, 1'b0);
                cnt = cnt + 1'b1;
            end else if (is_cont) begin
                res[cnt[IDX_W-1:0]] = raw_word(b, 1'b1);
                cnt = cnt + 1'b1;
            end else begin
                o_st.lead = b;
                o_st.seen = 2'd0;
                if (b[7:4] == 4'hf) begin
                    o_st.needed = NEED_THREE;
                    o_st.pv     = {{(CP_W-8){1'b0}}, b & MASK_LEAD4};
                end else if (b[7:5] == 3'b111) begin
                    o_st.needed = NEED_TWO;
                    o_st.pv     = {{(CP_W-8){1'b0}}, b & MASK_LEAD3};
                end else begin
                    o_st.needed = NEED_ONE;
                    o_st.pv     = {{(CP_W-8){1'b0}}, b & MASK_LEAD2};
                end
                if (i_in.text_end) begin
                    res[cnt[IDX_W-1:0]] = raw_word(b, 1'b1);
                    cnt = cnt + 1'b1;
                    o_st.needed = NEED_NONE;
                    o_st.seen   = 2'd0;
                    o_st.pv     = '0;
                end
            end
        end

        if (cnt != '0) begin
            res[IDX_W'(cnt - 1'b1)].run_last = 1'b1;
        end
    end

    assign o_list = res;
    assign o_cnt  = cnt;

endmodule

FILE: hw/rtl/u8d_outbuf.sv
// Result register: holds one byte's batch of words and hands them out one per cycle while the output is ready.
module u8d_outbuf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  u8d_pkg::t_out_list        i_list,
    input  logic [u8d_pkg::CNT_W-1:0] i_cnt,
    output logic                      o_free,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output u8d_pkg::t_out             o_out
);
    import u8d_pkg::*;

    t_out             r_res [MAX_RES];
    logic [CNT_W-1:0] r_left;
    logic [IDX_W-1:0] r_idx;
    logic             take;

    assign o_out_valid = (r_left != '0);
    assign take        = o_out_valid && i_out_ready;
    assign o_free      = (r_left == '0) || ((r_left == CNT_W'(1)) && i_out_ready);
    assign o_out       = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_cnt;
            r_idx  <= '0;
        end else if (take) begin
            r_left <= r_left - 1'b1;
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_res[k] <= i_list[k];
            end
        end
    end

endmodule

FILE: hw/rtl/utf8_stream_decoder_latin1_fallback.sv
// Top level of the UTF-8 stream decoder with Latin-1 fallback.
// Each accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the output is ready and bytes yield at most one word;
// a byte with more (fallback bursts, up to 4) holds the result register until they drain.
// Reset: synchronous, clears sequence state and both registers' valid state;
// held continuation bytes are not reset.
module utf8_stream_decoder_latin1_fallback (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  u8d_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output u8d_pkg::t_out o_out
);
    import u8d_pkg::*;

    logic                 r_in_valid;
    t_in                  r_in;
    t_dec_state           r_st;
    t_dec_state           n_st;
    logic [HC_N-1:0][7:0] r_hc;
    t_hc_wr               hc_wr;
    t_out_list            dec_list;
    logic [CNT_W-1:0]     dec_cnt;
    logic                 buf_free;
    logic                 load;

    assign load       = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (load) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && hc_wr.we) begin
            r_hc[hc_wr.addr] <= hc_wr.data;
        end
    end

    u8d_decode u_decode (
        .i_in    (r_in),
        .i_st    (r_st),
        .i_hc    (r_hc),
        .o_st    (n_st),
        .o_hc_wr (hc_wr),
        .o_list  (dec_list),
        .o_cnt   (dec_cnt)
    );

    u8d_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_list      (dec_list),
        .i_cnt       (dec_cnt),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_idle_no_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.needed == NEED_NONE) |-> (r_st.seen == 2'd0))
        else $error("continuations counted with no sequence pending");

    a_seen_below_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.needed != NEED_NONE) |-> (r_st.seen < r_st.needed))
        else $error("pending sequence already complete");

    a_idle_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.needed == NEED_NONE) |-> (r_st.pv == '0))
        else $error("stale partial value with no sequence pending");

    a_lead_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.needed != NEED_NONE) |-> (r_st.lead[7:6] == LEAD_TAG))
        else $error("pending sequence held by a non-lead byte");
`endif

endmodule
